@@ src/doppler_bandwidth_scan_core_macros.svh @@
// Assertion helpers shared by the scan modules.
// Each use needs clk and rst_n in scope.
`ifndef DOPPLER_BANDWIDTH_SCAN_CORE_MACROS_SVH
`define DOPPLER_BANDWIDTH_SCAN_CORE_MACROS_SVH

// Same-cycle implication.
`define DBS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("doppler_bandwidth_scan: same-cycle check failed");

// Next-cycle implication.
`define DBS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("doppler_bandwidth_scan: next-cycle check failed");

`endif

@@ src/dbs_pkg.sv @@
package dbs_pkg;

    localparam int WINDOW     = 33;
    localparam int BIN_COUNT  = 1024;
    localparam int STORE_LEN  = 2 * WINDOW + 1;
    localparam int ADDR_W     = $clog2(STORE_LEN);
    localparam int DIST_W     = $clog2(WINDOW + 1);

    localparam int BIN_W      = 10;
    localparam int MAG_W      = 24;
    localparam int RATIO_W    = 16;
    localparam int OUT_W      = 7;
    localparam int PROD_W     = MAG_W + RATIO_W;
    localparam int OFF_W      = BIN_W + 2;
    localparam int BSUM_W     = 14;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_PEAK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PILOT_BIN   = 2'd2;

    localparam logic [RATIO_W-1:0] MAX_VOL_RESET     = 16'd3277;
    localparam logic [RATIO_W-1:0] SECOND_PEAK_RESET = 16'd19661;
    localparam logic [BIN_W-1:0]   PILOT_BIN_RESET   = 10'd0;

    // Controller to datapath
    typedef struct packed {
        logic mul;
        logic side_init;
        logic side_right;
        logic step;
        logic k_latch;
        logic peak_upd;
        logic res_left;
        logic res_right;
        logic res_from_k;
        logic emit;
        logic clear;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic accept_last;
        logic above_max;
        logic above_sp;
        logic below_max;
        logic at_window;
        logic peak;
        logic side_right;
    } status_t;

endpackage

@@ src/dbs_ram.sv @@
module dbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 67
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

@@ src/dbs_datapath.sv @@
module dbs_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [dbs_pkg::BIN_W-1:0]         bin_index,
    input  logic [dbs_pkg::MAG_W-1:0]         magnitude,
    input  logic                              frame_last,
    input  logic                              cfg_write,
    input  logic [dbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dbs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  dbs_pkg::cmd_t                     cmd,
    output dbs_pkg::status_t                  status,
    output logic [dbs_pkg::OUT_W-1:0]         left_bandwidth,
    output logic [dbs_pkg::OUT_W-1:0]         right_bandwidth
);

    import dbs_pkg::*;

    localparam logic signed [OFF_W-1:0] WIN_S = OFF_W'(WINDOW);

    logic [RATIO_W-1:0]      max_vol_reg;
    logic [RATIO_W-1:0]      second_peak_reg;
    logic [BIN_W-1:0]        pilot_reg;
    logic [MAG_W-1:0]        pilot_mag_reg;
    logic [STORE_LEN-1:0]    valid_reg;
    logic [PROD_W-1:0]       prod_max_reg;
    logic [PROD_W-1:0]       prod_sp_reg;
    logic [PROD_W-1:0]       prod_max_next;
    logic [PROD_W-1:0]       prod_sp_next;
    logic                    side_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic [DIST_W-1:0]       k_reg;
    logic                    peak_reg;
    logic                    rd_ok_reg;
    logic [OUT_W-1:0]        left_reg;
    logic [OUT_W-1:0]        right_reg;

    logic signed [OFF_W-1:0] off;
    logic                    bin_ok;
    logic                    off_ok;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    in_spec;
    logic [MAG_W-1:0]        rd_data;
    logic [MAG_W-1:0]        bin_val;
    logic [PROD_W-1:0]       bin_ext;
    logic [DIST_W-1:0]       res_value;

    // Store write: keep bins within the window around the pilot
    assign off     = $signed({2'b00, bin_index}) - $signed({2'b00, pilot_reg});
    assign bin_ok  = BSUM_W'(bin_index) < BSUM_W'(BIN_COUNT);
    assign off_ok  = (off >= -WIN_S) && (off <= WIN_S);
    assign wr_en   = accept && bin_ok && off_ok;
    assign wr_addr = ADDR_W'(off + WIN_S);

    // Scan read address and spectrum edge check
    assign rd_addr = side_reg ? (ADDR_W'(WINDOW) + ADDR_W'(dist_reg))
                              : (ADDR_W'(WINDOW) - ADDR_W'(dist_reg));
    assign in_spec = side_reg
        ? ((BSUM_W'(pilot_reg) + BSUM_W'(dist_reg)) < BSUM_W'(BIN_COUNT))
        : (BSUM_W'(dist_reg) <= BSUM_W'(pilot_reg));

    dbs_ram #(
        .WIDTH (MAG_W),
        .DEPTH (STORE_LEN)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (magnitude),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign prod_max_next = max_vol_reg * pilot_mag_reg;
    assign prod_sp_next  = second_peak_reg * pilot_mag_reg;

    // Unwritten or off-spectrum bins read as zero
    assign bin_val = rd_ok_reg ? rd_data : '0;
    assign bin_ext = {bin_val, {RATIO_W{1'b0}}};

    assign res_value = cmd.res_from_k ? k_reg : dist_reg;

    always_comb
    begin
        status.accept_last = accept && frame_last;
        status.above_max   = bin_ext > prod_max_reg;
        status.above_sp    = bin_ext > prod_sp_reg;
        status.below_max   = bin_ext < prod_max_reg;
        status.at_window   = dist_reg == DIST_W'(WINDOW);
        status.peak        = peak_reg;
        status.side_right  = side_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_vol_reg     <= MAX_VOL_RESET;
            second_peak_reg <= SECOND_PEAK_RESET;
            pilot_reg       <= PILOT_BIN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MAX_VOL:     max_vol_reg     <= cfg_data[RATIO_W-1:0];
                CFG_SECOND_PEAK: second_peak_reg <= cfg_data[RATIO_W-1:0];
                CFG_PILOT_BIN:   pilot_reg       <= cfg_data[BIN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            pilot_mag_reg <= '0;
        end
        else if (cmd.clear)
        begin
            valid_reg     <= '0;
            pilot_mag_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
            if (off == '0)
            begin
                pilot_mag_reg <= magnitude;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg  <= 1'b0;
            dist_reg  <= '0;
            k_reg     <= '0;
            peak_reg  <= 1'b0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= valid_reg[rd_addr] && in_spec;
            if (cmd.side_init)
            begin
                side_reg <= cmd.side_right;
                dist_reg <= DIST_W'(1);
                peak_reg <= 1'b0;
            end
            else
            begin
                if (cmd.step)
                begin
                    dist_reg <= dist_reg + DIST_W'(1);
                end
                if (cmd.peak_upd)
                begin
                    peak_reg <= peak_reg || status.above_sp;
                end
            end
            if (cmd.k_latch)
            begin
                k_reg <= dist_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_max_reg <= prod_max_next;
            prod_sp_reg  <= prod_sp_next;
        end
        if (cmd.res_left)
        begin
            left_reg <= OUT_W'(res_value);
        end
        if (cmd.res_right)
        begin
            right_reg <= OUT_W'(res_value);
        end
    end

    assign left_bandwidth  = left_reg;
    assign right_bandwidth = right_reg;

`include "doppler_bandwidth_scan_core_macros.svh"

    `DBS_ASSERT_IMP(a_res_range, cmd.res_left || cmd.res_right, (res_value != '0) && (res_value <= DIST_W'(WINDOW)))
    `DBS_ASSERT_NXT(a_clear_empty, cmd.clear, (valid_reg == '0) && (pilot_mag_reg == '0))
    `DBS_ASSERT_IMP(a_no_store_in_scan, cmd.step || cmd.mul, !wr_en)

endmodule

@@ src/dbs_ctrl.sv @@
module dbs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  dbs_pkg::status_t status,
    output dbs_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done
);

    import dbs_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MUL    = 7'b0000010,
        ST_W1_RD  = 7'b0000100,
        ST_W1_CMP = 7'b0001000,
        ST_W2_RD  = 7'b0010000,
        ST_W2_CMP = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   fin;
    logic   fin_k;
    logic   peak_now;

    assign peak_now = status.peak || status.above_sp;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        fin        = 1'b0;
        fin_k      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.accept_last)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul        = 1'b1;
                cmd.side_init  = 1'b1;
                cmd.side_right = 1'b0;
                state_next     = ST_W1_RD;
            end
            ST_W1_RD:
            begin
                state_next = ST_W1_CMP;
            end
            ST_W1_CMP:
            begin
                if (status.above_max && !status.at_window)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_W1_RD;
                end
                else
                begin
                    cmd.k_latch = 1'b1;
                    if (status.at_window)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        // move past the minimum and hunt for a split-off peak
                        cmd.step   = 1'b1;
                        state_next = ST_W2_RD;
                    end
                end
            end
            ST_W2_RD:
            begin
                state_next = ST_W2_CMP;
            end
            ST_W2_CMP:
            begin
                cmd.peak_upd = 1'b1;
                if (peak_now && status.below_max)
                begin
                    fin = 1'b1;
                end
                else if (!status.at_window)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_W2_RD;
                end
                else
                begin
                    fin   = 1'b1;
                    fin_k = !peak_now;
                end
            end
            ST_DONE:
            begin
                cmd.emit   = 1'b1;
                cmd.clear  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // side finished: latch its width, then turn right or wrap up
        if (fin)
        begin
            cmd.res_from_k = fin_k;
            if (!status.side_right)
            begin
                cmd.res_left   = 1'b1;
                cmd.side_init  = 1'b1;
                cmd.side_right = 1'b1;
                state_next     = ST_W1_RD;
            end
            else
            begin
                cmd.res_right = 1'b1;
                state_next    = ST_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != ST_IDLE;
    assign done = state_reg == ST_DONE;

`include "doppler_bandwidth_scan_core_macros.svh"

    `DBS_ASSERT_NXT(a_done_pulse, done, !done)
    `DBS_ASSERT_NXT(a_last_starts_scan, status.accept_last, busy && cmd.mul)
    `DBS_ASSERT_IMP(a_idle_quiet, !busy, !cmd.step && !cmd.emit && !cmd.k_latch)

endmodule

@@ src/doppler_bandwidth_scan_core.sv @@
// Channel   | Handshake               | Payload
// ----------+-------------------------+--------------------------------------------
// bins in   | start and not busy      | bin_index, magnitude, frame_last
// result    | done (one-cycle strobe) | left_bandwidth, right_bandwidth
// config    | cfg_write               | cfg_index, cfg_data
//
// Bins are taken one per cycle while busy is low. A beat with frame_last set
// starts the scan: the ratio products are formed, then each bin visited is
// read and then compared (store read is registered), at most WINDOW bins per
// side, then the done state, with busy high throughout.
// Reset loads the register defaults and empties the bin store and the pilot
// magnitude; the store is emptied again in the done cycle. No result stall.
module doppler_bandwidth_scan_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [dbs_pkg::BIN_W-1:0]         bin_index,
    input  logic [dbs_pkg::MAG_W-1:0]         magnitude,
    input  logic                              frame_last,
    output logic                              done,
    output logic [dbs_pkg::OUT_W-1:0]         left_bandwidth,
    output logic [dbs_pkg::OUT_W-1:0]         right_bandwidth,
    input  logic                              cfg_write,
    input  logic [dbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dbs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import dbs_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    accept;

    assign accept = start && !busy;

    dbs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    dbs_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .bin_index       (bin_index),
        .magnitude       (magnitude),
        .frame_last      (frame_last),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .status          (status),
        .left_bandwidth  (left_bandwidth),
        .right_bandwidth (right_bandwidth)
    );

endmodule
